### rtl/cha_pkg.sv
// ----------------------------------------------------------------------------
// cha_pkg
// shared constants, types and cordic angle table for the heading smoother
// ----------------------------------------------------------------------------
package cha_pkg;

  localparam int AngleBits  = 16;
  localparam int CountBits  = 16;
  localparam int CordicIter = 24;
  localparam int TimeBits   = 40;
  localparam int CfgBits    = 16;
  localparam int AccBits    = 50;
  localparam int DivBits    = 40;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [15:0] WeightOne = 16'd32768;
  localparam logic signed [AccBits-1:0] GainStart = AccBits'(652032874);

  localparam logic [0:0] RegWindow   = 1'b0;
  localparam logic [0:0] RegInterval = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StDivN, StDivW, StRotOld, StRotNew, StMix, StVec, StDone
  } state_e;

  // cordic unit commands
  typedef enum logic [1:0] {
    OpRotate, OpVector
  } cordic_op_e;

  typedef struct packed {
    logic             start;
    cordic_op_e       op;
    logic [31:0]      angle;
    logic signed [AccBits-1:0] x;
    logic signed [AccBits-1:0] y;
  } cordic_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [AccBits-1:0] x;
    logic signed [AccBits-1:0] y;
    logic [31:0]               z;
  } cordic_rsp_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41721;
        5'd15: r = 32'd20860;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2607;
        5'd19: r = 32'd1303;
        5'd20: r = 32'd651;
        5'd21: r = 32'd325;
        5'd22: r = 32'd162;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] quantize(input logic [31:0] a);
    logic [31:0] s;
    begin
      s = a + (32'd1 << (31 - AngleBits));
      return (s >> (32 - AngleBits)) << (32 - AngleBits);
    end
  endfunction

endpackage

### rtl/cha_div.sv
// ----------------------------------------------------------------------------
// cha_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cha_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cha_pkg::DivBits-1:0] num_i,
  input  logic [cha_pkg::DivBits-1:0] den_i,
  output logic                        done_o,
  output logic [cha_pkg::DivBits-1:0] quo_o
);

  localparam int CntW = $clog2(cha_pkg::DivBits + 1);

  logic [cha_pkg::DivBits-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;
  logic [cha_pkg::DivBits:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[cha_pkg::DivBits-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = CntW'(cha_pkg::DivBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[cha_pkg::DivBits]) begin
        rem_d = trial[cha_pkg::DivBits-1:0];
        quo_d = {quo_q[cha_pkg::DivBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[cha_pkg::DivBits-2:0], quo_q[cha_pkg::DivBits-1]};
        quo_d = {quo_q[cha_pkg::DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/cha_cordic.sv
// ----------------------------------------------------------------------------
// cha_cordic
// shared cordic, one micro-rotation per cycle, rotation and vectoring modes
// ----------------------------------------------------------------------------
module cha_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cha_pkg::cordic_req_t req_i,
  output cha_pkg::cordic_rsp_t rsp_o
);

  localparam int W = cha_pkg::AccBits;

  logic signed [W-1:0] x_q, x_d, y_q, y_d;
  logic signed [33:0]  z_q, z_d;
  logic [4:0]          i_q, i_d;
  logic                busy_q, busy_d, done_q, done_d, flip_q, flip_d;
  cha_pkg::cordic_op_e op_q, op_d;
  logic signed [W-1:0] xs, ys;
  logic signed [33:0]  za, zin;
  logic                dir;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    busy_d = busy_q; done_d = 1'b0; flip_d = flip_q; op_d = op_q;
    xs  = x_q >>> i_q;
    ys  = y_q >>> i_q;
    za  = {2'b00, cha_pkg::atan_lut(i_q)};
    dir = (op_q == cha_pkg::OpRotate) ? !z_q[33] : (y_q > 0);
    zin = 34'(signed'(req_i.angle));
    if (req_i.start) begin
      busy_d = 1'b1;
      i_d    = '0;
      op_d   = req_i.op;
      flip_d = 1'b0;
      if (req_i.op == cha_pkg::OpRotate) begin
        x_d = cha_pkg::GainStart;
        y_d = '0;
        z_d = zin;
        if (zin > 34'sd1073741824) begin
          z_d = zin - 34'sd2147483648; flip_d = 1'b1;
        end else if (zin < -34'sd1073741824) begin
          z_d = zin + 34'sd2147483648; flip_d = 1'b1;
        end
      end else begin
        if (req_i.x < 0) begin
          x_d = -req_i.x; y_d = -req_i.y; z_d = 34'sd2147483648;
        end else begin
          x_d = req_i.x; y_d = req_i.y; z_d = '0;
        end
      end
    end else if (busy_q) begin
      if (dir) begin
        if (op_q == cha_pkg::OpRotate) begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - za;
        end else begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + za;
        end
      end else begin
        if (op_q == cha_pkg::OpRotate) begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + za;
        end else begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - za;
        end
      end
      i_d = i_q + 1'b1;
      if (i_q == 5'(cha_pkg::CordicIter - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      op_q   <= cha_pkg::OpRotate;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.x    = flip_q ? -x_q : x_q;
  assign rsp_o.y    = flip_q ? -y_q : y_q;
  assign rsp_o.z    = z_q[31:0];

endmodule

### rtl/circular_heading_average.sv
// ----------------------------------------------------------------------------
// circular_heading_average
// circular moving average of yaw using a shared cordic and serial divider
//
//   channel | dir | tdata (low bit up)            | tuser
//   s_axis  | in  | sample_time[39:0], yaw[55:40] | -
//   m_axis  | out | smoothed_yaw[15:0]            | window_full
//   cfg     | in  | wr_data[15:0], idx 0 window, 1 interval
//
// when dt is zero the rounded new yaw becomes the heading; otherwise two
// 40-step divides, three 24-step cordic passes and a mix step, the
// vectoring pass being skipped when the mixed vector is zero
// s_axis_tready is low from acceptance until the result transfer
// a stalled result transfer holds the block in its done state
// no clearing pass after reset
// ----------------------------------------------------------------------------
module circular_heading_average (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // sample_time, yaw_angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // smoothed_yaw
  output logic        m_axis_tuser,   // window_full
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int DB = cha_pkg::DivBits;
  localparam int CB = cha_pkg::CountBits;
  localparam int AW = cha_pkg::AccBits;

  cha_pkg::state_e st_q, st_d;
  logic [15:0] win_q, ivl_q;
  logic        started_q, started_d, full_q, full_d;
  logic [31:0] head_q, head_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic [cha_pkg::TimeBits-1:0] last_q, last_d;
  logic [cha_pkg::TimeBits-1:0] tin_q, dt;
  logic [31:0] yaw_q;
  logic [15:0] w_q, w_d;
  logic signed [AW-1:0] co_q, so_q, co_d, so_d;
  logic [CB-1:0] k_q, k_d;

  logic          div_start;
  logic [DB-1:0] div_num, div_den, div_quo;
  logic          div_done;
  cha_pkg::cordic_req_t creq;
  cha_pkg::cordic_rsp_t crsp;
  logic signed [AW-1:0] mx, my;
  logic signed [17:0] wo, wn;
  logic [DB-1:0] n_eff;

  cha_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  cha_cordic u_cordic (.clk_i, .rst_ni, .req_i(creq), .rsp_o(crsp));

  assign dt = tin_q - last_q;
  assign n_eff = (div_quo == '0) ? DB'(1) : div_quo;
  assign wo = 18'(cha_pkg::WeightOne) - 18'(w_q);
  assign wn = 18'(w_q);
  assign mx = AW'(wo * co_q) + AW'(wn * crsp.x);
  assign my = AW'(wo * so_q) + AW'(wn * crsp.y);

  always_comb begin
    st_d = st_q; started_d = started_q; full_d = full_q; head_d = head_q;
    cnt_d = cnt_q; last_d = last_q; w_d = w_q; co_d = co_q; so_d = so_q;
    k_d = k_q;
    div_start = 1'b0; div_num = '0; div_den = DB'(1);
    creq = '0;
    unique case (st_q)
      cha_pkg::StIdle: begin
        if (s_axis_tvalid) begin
          if (!started_q) begin
            started_d = 1'b1;
            last_d = s_axis_tdata[39:0];
          end else if (s_axis_tdata[39:0] < last_q) begin
            cnt_d = CB'(1);
            full_d = 1'b0;
            last_d = s_axis_tdata[39:0];
          end
          st_d = cha_pkg::StDivN;
        end
      end
      cha_pkg::StDivN: begin
        if (dt == '0) begin
          head_d = cha_pkg::quantize(yaw_q);
          st_d = cha_pkg::StDone;
        end else begin
          div_start = 1'b1;
          div_num = DB'(win_q);
          div_den = (ivl_q != '0) ? DB'(ivl_q) : dt;
          st_d = cha_pkg::StDivW;
        end
      end
      cha_pkg::StDivW: begin
        if (div_done && k_q == '0) begin
          full_d = DB'(cnt_q) >= n_eff;
          k_d = (DB'(cnt_q) < n_eff) ? cnt_q : CB'(n_eff);
          if (k_d == '0) k_d = CB'(1);
          div_start = 1'b1;
          div_num = DB'(cha_pkg::WeightOne) + DB'(k_d >> 1);
          div_den = DB'(k_d);
        end else if (div_done) begin
          w_d = div_quo[15:0];
          creq.start = 1'b1;
          creq.op = cha_pkg::OpRotate;
          creq.angle = head_q;
          st_d = cha_pkg::StRotOld;
        end
      end
      cha_pkg::StRotOld: begin
        if (crsp.done) begin
          co_d = crsp.x;
          so_d = crsp.y;
          creq.start = 1'b1;
          creq.op = cha_pkg::OpRotate;
          creq.angle = yaw_q;
          st_d = cha_pkg::StRotNew;
        end
      end
      cha_pkg::StRotNew: begin
        if (crsp.done) begin
          co_d = mx;
          so_d = my;
          st_d = cha_pkg::StMix;
        end
      end
      cha_pkg::StMix: begin
        if (co_q == '0 && so_q == '0) begin
          head_d = '0;
          st_d = cha_pkg::StDone;
        end else begin
          creq.start = 1'b1;
          creq.op = cha_pkg::OpVector;
          creq.x = co_q;
          creq.y = so_q;
          st_d = cha_pkg::StVec;
        end
      end
      cha_pkg::StVec: begin
        if (crsp.done) begin
          head_d = cha_pkg::quantize(crsp.z);
          st_d = cha_pkg::StDone;
        end
      end
      cha_pkg::StDone: begin
        if (m_axis_tready) st_d = cha_pkg::StIdle;
      end
      default: st_d = cha_pkg::StIdle;
    endcase
    if (st_q != cha_pkg::StDone && st_d == cha_pkg::StDone) begin
      if (cnt_d < cha_pkg::CountMax) cnt_d = cnt_d + 1'b1;
      last_d = tin_q;
    end
    if (st_q == cha_pkg::StIdle) k_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cha_pkg::StIdle;
      win_q <= 16'd1000;
      ivl_q <= '0;
      started_q <= 1'b0;
      full_q <= 1'b0;
      head_q <= '0;
      cnt_q <= CB'(1);
      last_q <= '0;
      k_q <= '0;
    end else begin
      st_q <= st_d;
      started_q <= started_d;
      full_q <= full_d;
      head_q <= head_d;
      cnt_q <= cnt_d;
      last_q <= last_d;
      k_q <= k_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == cha_pkg::RegWindow) win_q <= cfg_data_i;
        else ivl_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == cha_pkg::StIdle) begin
      tin_q <= s_axis_tdata[39:0];
      yaw_q <= {s_axis_tdata[55:40], 16'h0000};
    end
    w_q <= w_d;
    co_q <= co_d;
    so_q <= so_d;
  end

  assign s_axis_tready = (st_q == cha_pkg::StIdle);
  assign m_axis_tvalid = (st_q == cha_pkg::StDone);
  assign m_axis_tdata  = 16'((head_q + 32'h8000) >> 16);
  assign m_axis_tuser  = full_q;

endmodule

### rtl/cha_checker.sv
// ----------------------------------------------------------------------------
// cha_checker
// port-level checks for the heading smoother, bound to the top level
// ----------------------------------------------------------------------------
module cha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after transfer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser)) else $error("result dropped");

  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready) else $error("not ready after output");

endmodule

bind circular_heading_average cha_checker u_cha_checker (.*);

### tb/heading_checker.sv
// ----------------------------------------------------------------------------
// heading_checker
// watches the sample and result channels, predicts each smoothed heading with
// a bit-exact cordic model and compares it with the block's output
// ----------------------------------------------------------------------------
module heading_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] yaw;
    logic        full;
  } heading_res_t;

  localparam longint TurnAtan [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20860, 10430, 5215,
    2607, 1303, 651, 325, 162, 81};

  heading_res_t heading_q[$];
  logic [15:0] win_r, ivl_r;
  logic        run_r, full_r;
  logic [31:0] head_r;
  logic [15:0] cnt_r;
  logic [39:0] tlast_r;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = heading_q.size();

  function automatic logic [31:0] round_angle(input logic [31:0] a);
    logic [31:0] s;
    s = a + (32'd1 << (31 - cha_pkg::AngleBits));
    return (s >> (32 - cha_pkg::AngleBits)) << (32 - cha_pkg::AngleBits);
  endfunction

  function automatic void unit_vec(input logic [31:0] a, output longint c,
                                   output longint s);
    longint z, x, y, nx, ny;
    bit flip;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1'b1;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= TurnAtan[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += TurnAtan[i];
      end
      x = nx; y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] vec_phase(input longint xi, input longint yi);
    longint x, y, z, nx, ny;
    x = xi; y = yi; z = 0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd2147483648;
    end
    for (int i = 0; i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += TurnAtan[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= TurnAtan[i];
      end
      x = nx; y = ny;
    end
    return z[31:0];
  endfunction

  task automatic predict_heading(input logic [39:0] t, input logic [15:0] yaw);
    logic [31:0] yaw32;
    logic [39:0] dt, d, n, k, w;
    longint co, so, cn, sn, mx, my;
    heading_res_t r;
    yaw32 = {yaw, 16'h0};
    if (!run_r) begin
      run_r = 1'b1; tlast_r = t;
    end else if (t < tlast_r) begin
      cnt_r = 16'd1; full_r = 1'b0; tlast_r = t;
    end
    dt = t - tlast_r;
    if (dt == '0) begin
      head_r = round_angle(yaw32);
    end else begin
      d = (ivl_r != '0) ? 40'(ivl_r) : dt;
      n = 40'(win_r) / d;
      if (n == '0) n = 40'd1;
      full_r = 40'(cnt_r) >= n;
      k = (40'(cnt_r) < n) ? 40'(cnt_r) : n;
      if (k == '0) k = 40'd1;
      w = (40'd32768 + k / 2) / k;
      unit_vec(head_r, co, so);
      unit_vec(yaw32, cn, sn);
      mx = (32768 - longint'(w)) * co + longint'(w) * cn;
      my = (32768 - longint'(w)) * so + longint'(w) * sn;
      head_r = round_angle(vec_phase(mx, my));
    end
    if (cnt_r != cha_pkg::CountMax) cnt_r++;
    tlast_r = t;
    r.yaw  = 16'((head_r + 32'h8000) >> 16);
    r.full = full_r;
    heading_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heading_res_t e;
    if (!rst_ni) begin
      win_r = 16'd1000; ivl_r = '0; run_r = 1'b0; head_r = '0; cnt_r = 16'd1;
      full_r = 1'b0; tlast_r = '0; fails = 0;
      heading_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == cha_pkg::RegWindow) win_r = cfg_data_i;
        else ivl_r = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (heading_q.size() == 0) begin
          $display("%0t unexpected transfer yaw %h full %b", $time,
                   m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          e = heading_q.pop_front();
          if (e.yaw !== m_axis_tdata || e.full !== m_axis_tuser) begin
            $display("%0t mismatch expected yaw %h full %b actual yaw %h full %b",
                     $time, e.yaw, e.full, m_axis_tdata, m_axis_tuser);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_heading(s_axis_tdata[39:0], s_axis_tdata[55:40]);
    end
  end
endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives timestamped yaw samples through the heading smoother under several
// register settings and random stalls; the checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0, rst_ni = 0;
  logic        s_axis_tvalid = 0, s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid, m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 0;
  logic [0:0]  cfg_idx_i = cha_pkg::RegWindow;
  logic [15:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          send_idle = 0, recv_idle = 0;
  bit          hold_off = 0;
  int          quiet = 0;
  logic [39:0] now_ms = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  circular_heading_average i_dut (.*);

  heading_checker i_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending));

  // receiver
  always @(negedge clk_i)
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic send_sample(input logic [39:0] t, input logic [15:0] yaw);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {yaw, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic random_run(input int cnt);
    logic [39:0] step;
    for (int i = 0; i < cnt; i++) begin
      step = ($urandom_range(9) == 0) ? 40'({$urandom, $urandom} & 64'hF_FFFF)
                                      : 40'($urandom_range(40));
      case ($urandom_range(19))
        0: now_ms = 40'({$urandom, $urandom});
        1: now_ms = now_ms - 40'($urandom_range(5000));
        2: step = '0;
        default: ;
      endcase
      now_ms = now_ms + step;
      send_sample(now_ms, 16'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: reset settings, extremes, restart, zero step, wrap near pi
    send_sample(40'd0, 16'h0000);
    send_sample(40'd0, 16'h7FFF);
    send_sample(40'd10, 16'h8000);
    send_sample(40'd20, 16'h7FFF);
    send_sample(40'd30, 16'h4000);
    send_sample(40'd40, 16'hC000);
    send_sample(40'd5, 16'h2000);
    send_sample(40'hFF_FFFF_FFFF, 16'hFFFF);
    send_sample(40'hFF_FFFF_FFFF, 16'h0001);
    send_sample(40'd1, 16'h4001);
    send_sample(40'd1001, 16'hBFFF);
    send_sample(40'd2001, 16'h8001);
    drain();
    write_reg(cha_pkg::RegWindow, 16'd0);
    write_reg(cha_pkg::RegInterval, 16'hFFFF);
    send_sample(40'd3000, 16'h1234);
    send_sample(40'd3001, 16'hEDCB);
    send_sample(40'd3002, 16'h5555);
    drain();
    write_reg(cha_pkg::RegWindow, 16'hFFFF);
    write_reg(cha_pkg::RegInterval, 16'd1);
    for (int i = 0; i < 6; i++) send_sample(40'd4000 + 40'(i), 16'hAAAA ^ 16'(i));
    drain();

    send_idle = 6; recv_idle = 83;
    write_reg(cha_pkg::RegWindow, 16'd50); write_reg(cha_pkg::RegInterval, 16'd0);
    random_run(100);
    drain();
    write_reg(cha_pkg::RegWindow, 16'd1000); write_reg(cha_pkg::RegInterval, 16'd7);
    // long receiver hold-off while samples keep coming
    fork
      begin
        hold_off = 1;
        repeat (2000) @(negedge clk_i);
        hold_off = 0;
      end
      random_run(10);
    join
    send_idle = 83; recv_idle = 6;
    random_run(100);
    drain();
    write_reg(cha_pkg::RegWindow, 16'hFFFF); write_reg(cha_pkg::RegInterval, 16'd0);
    random_run(160);
    drain();
    send_idle = 0; recv_idle = 0;
    write_reg(cha_pkg::RegWindow, 16'd0); write_reg(cha_pkg::RegInterval, 16'd3);
    random_run(80);
    drain();
    write_reg(cha_pkg::RegWindow, 16'd200); write_reg(cha_pkg::RegInterval, 16'd0);
    random_run(180);
    drain();

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
